### rtl/core/lap5_pkg.sv
package lap5_pkg;

  localparam int MAX_COLS   = 4096;
  localparam int MAX_ROWS   = 4096;
  localparam int SAMPLE_W   = 32;
  localparam int SCALE_W    = 26;
  localparam int EXT_W      = 13;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int ADDR_W     = $clog2(MAX_COLS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  // a - 2b + c over signed samples needs two more bits
  localparam int DIFF_W     = SAMPLE_W + 2;
  localparam int PROD_W     = DIFF_W + SCALE_W + 1;
  localparam int LAP_W      = 64;
  localparam int MIN_EXT    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COLS = 2'd3;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_rows;
    logic [SCALE_W-1:0] scale_cols;
  } scale_t;

  // one accepted sample after the row store read is issued
  typedef struct packed {
    logic                       has_result;
    logic                       last_point;
    logic [ROW_W-1:0]           center_row;
    logic [COL_W-1:0]           center_col;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] sample;
  } s1_t;

  // position fields that ride along with the arithmetic
  typedef struct packed {
    logic             last_point;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
  } pos_t;

  function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v,
                                                 input logic [EXT_W-1:0] hi);
    logic [EXT_W-1:0] res;
    res = v;
    if (v < EXT_W'(MIN_EXT)) begin
      res = EXT_W'(MIN_EXT);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

### rtl/core/lap5_ram.sv
module lap5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lap5_ctrl.sv
module lap5_ctrl
  import lap5_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       in_stall,
  input  logic                       s2_ready,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          rd_addr,
  output logic                       s1_valid,
  output s1_t                        s1,
  output scale_t                     scales
);

  logic [EXT_W-1:0]   grid_rows_r, grid_rows_nxt;
  logic [EXT_W-1:0]   grid_cols_r, grid_cols_nxt;
  logic [SCALE_W-1:0] scale_rows_r, scale_rows_nxt;
  logic [SCALE_W-1:0] scale_cols_r, scale_cols_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  s1_t                s1_r, s1_nxt;
  logic               s1_ready;
  logic               accept;
  logic [EXT_W-1:0]   row_inc;
  logic [EXT_W-1:0]   col_inc;

  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;
  assign row_inc  = {1'b0, row_r} + EXT_W'(1);
  assign col_inc  = {1'b0, col_r} + EXT_W'(1);

  assign rd_en    = accept;
  assign rd_addr  = col_r[ADDR_W-1:0];
  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign scales   = '{scale_rows: scale_rows_r, scale_cols: scale_cols_r};

  always_comb begin
    grid_rows_nxt  = grid_rows_r;
    grid_cols_nxt  = grid_cols_r;
    scale_rows_nxt = scale_rows_r;
    scale_cols_nxt = scale_cols_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    s1_valid_nxt   = s1_valid_r;
    s1_nxt         = s1_r;

    if (s1_ready) begin
      s1_valid_nxt = accept;
    end

    if (accept) begin
      s1_nxt.has_result = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_nxt.last_point = (row_inc == grid_rows_r) && (col_inc == grid_cols_r);
      s1_nxt.center_row = row_r - ROW_W'(1);
      s1_nxt.center_col = col_r - COL_W'(1);
      s1_nxt.addr       = col_r[ADDR_W-1:0];
      s1_nxt.sample     = in_sample_value;
      if (col_inc >= grid_cols_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= grid_rows_r) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end

    // grid writes restart the frame
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: begin
          grid_rows_nxt = clamp_ext(cfg_wdata[EXT_W-1:0], EXT_W'(MAX_ROWS));
          row_nxt       = '0;
          col_nxt       = '0;
        end
        REG_GRID_COLS: begin
          grid_cols_nxt = clamp_ext(cfg_wdata[EXT_W-1:0], EXT_W'(MAX_COLS));
          row_nxt       = '0;
          col_nxt       = '0;
        end
        REG_SCALE_ROWS: scale_rows_nxt = cfg_wdata[SCALE_W-1:0];
        REG_SCALE_COLS: scale_cols_nxt = cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= EXT_W'(MAX_ROWS);
      grid_cols_r  <= EXT_W'(MAX_COLS);
      scale_rows_r <= SCALE_W'(16777216);
      scale_cols_r <= SCALE_W'(16777216);
      row_r        <= '0;
      col_r        <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      grid_rows_r  <= grid_rows_nxt;
      grid_cols_r  <= grid_cols_nxt;
      scale_rows_r <= scale_rows_nxt;
      scale_cols_r <= scale_cols_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

### rtl/core/lap5_win.sv
module lap5_win
  import lap5_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s1_valid,
  input  s1_t                      s1,
  output logic                     s2_ready,
  input  logic [SAMPLE_W-1:0]      older_rdata,
  input  logic [SAMPLE_W-1:0]      newer_rdata,
  output logic                     wr_en,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic [SAMPLE_W-1:0]      older_wdata,
  output logic [SAMPLE_W-1:0]      newer_wdata,
  input  logic                     s3_ready,
  output logic                     s2_valid,
  output logic signed [DIFF_W-1:0] d_row,
  output logic signed [DIFF_W-1:0] d_col,
  output pos_t                     s2_pos
);

  logic signed [SAMPLE_W-1:0] win0_r, win1_r, win2_r;
  logic signed [SAMPLE_W-1:0] held_up_r, held_down_r;
  logic signed [SAMPLE_W-1:0] nw0, nw1, nw2;
  logic                       s2_valid_r;
  logic signed [DIFF_W-1:0]   d_row_r, d_row_nxt;
  logic signed [DIFF_W-1:0]   d_col_r, d_col_nxt;
  pos_t                       pos_r;
  logic                       fire;

  assign s2_ready = !s2_valid_r || s3_ready;
  assign fire     = s1_valid && s2_ready;

  // window after this column's row-above sample shifts in
  assign nw0 = win1_r;
  assign nw1 = win2_r;
  assign nw2 = $signed(newer_rdata);

  assign d_row_nxt = DIFF_W'(held_up_r) - (DIFF_W'(nw1) <<< 1) + DIFF_W'(held_down_r);
  assign d_col_nxt = DIFF_W'(nw0) - (DIFF_W'(nw1) <<< 1) + DIFF_W'(nw2);

  // row above moves to the older store, the new sample to the newer store
  assign wr_en       = fire;
  assign wr_addr     = s1.addr;
  assign older_wdata = newer_rdata;
  assign newer_wdata = s1.sample;

  assign s2_valid = s2_valid_r;
  assign d_row    = d_row_r;
  assign d_col    = d_col_r;
  assign s2_pos   = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r      <= '0;
      win1_r      <= '0;
      win2_r      <= '0;
      held_up_r   <= '0;
      held_down_r <= '0;
      s2_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        win0_r      <= nw0;
        win1_r      <= nw1;
        win2_r      <= nw2;
        held_up_r   <= $signed(older_rdata);
        held_down_r <= s1.sample;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid && s1.has_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      d_row_r <= d_row_nxt;
      d_col_r <= d_col_nxt;
      pos_r   <= '{last_point: s1.last_point,
                   center_row: s1.center_row,
                   center_col: s1.center_col};
    end
  end

endmodule

### rtl/core/lap5_mac.sv
module lap5_mac
  import lap5_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  scale_t                   scales,
  input  logic                     s2_valid,
  input  logic signed [DIFF_W-1:0] d_row,
  input  logic signed [DIFF_W-1:0] d_col,
  input  pos_t                     s2_pos,
  output logic                     s3_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [LAP_W-1:0]  out_laplacian,
  output logic [ROW_W-1:0]         out_center_row,
  output logic [COL_W-1:0]         out_center_col,
  output logic                     out_last_point
);

  logic                      s3_valid_r;
  logic signed [PROD_W-1:0]  prod_row_r, prod_row_nxt;
  logic signed [PROD_W-1:0]  prod_col_r, prod_col_nxt;
  pos_t                      pos3_r;
  logic                      out_valid_r;
  logic signed [LAP_W-1:0]   lap_r, lap_nxt;
  pos_t                      pos_out_r;
  logic                      out_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign s3_ready  = !s3_valid_r || out_ready;

  assign prod_row_nxt = PROD_W'(d_row * $signed({1'b0, scales.scale_rows}));
  assign prod_col_nxt = PROD_W'(d_col * $signed({1'b0, scales.scale_cols}));
  assign lap_nxt      = LAP_W'(prod_row_r) + LAP_W'(prod_col_r);

  assign out_valid      = out_valid_r;
  assign out_laplacian  = lap_r;
  assign out_center_row = pos_out_r.center_row;
  assign out_center_col = pos_out_r.center_col;
  assign out_last_point = pos_out_r.last_point;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= s2_valid;
      end
      if (out_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      prod_row_r <= prod_row_nxt;
      prod_col_r <= prod_col_nxt;
      pos3_r     <= s2_pos;
    end
    if (out_ready && s3_valid_r) begin
      lap_r     <= lap_nxt;
      pos_out_r <= pos3_r;
    end
  end

endmodule

### rtl/core/laplacian_5point_stencil.sv
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_sample_value (s32 q16.16)
// out       output     out_valid/out_stall out_laplacian (s64), out_center_row,
//                                          out_center_col, out_last_point
// cfg       input      cfg_we             cfg_index, cfg_wdata
//
// one sample per cycle sustained while out_stall is low; a result passes through
// four registered stages (row store read, window and differences, multiply, sum)
// the two row stores are simple dual-port rams, one read and one write per cycle
// synchronous active-low reset clears counters, window and valids and restores config defaults; no store clear
// a stalled output backs up stage by stage; empty stages still take transfers
// samples that fall on the border update the stores but produce no transfer out
module laplacian_5point_stencil
  import lap5_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [LAP_W-1:0]    out_laplacian,
  output logic [ROW_W-1:0]           out_center_row,
  output logic [COL_W-1:0]           out_center_col,
  output logic                       out_last_point
);

  // stage handshakes
  logic                     s2_ready;
  logic                     s3_ready;
  logic                     s1_valid;
  logic                     s2_valid;
  s1_t                      s1;
  pos_t                     s2_pos;
  scale_t                   scales;

  // row store ports, shared write address for both stores
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [SAMPLE_W-1:0]      older_rdata, newer_rdata;
  logic [SAMPLE_W-1:0]      older_wdata, newer_wdata;

  logic signed [DIFF_W-1:0] d_row, d_col;

  // config, counters and the read issue at transfer
  lap5_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_sample_value (in_sample_value),
    .in_stall        (in_stall),
    .s2_ready        (s2_ready),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .s1_valid        (s1_valid),
    .s1              (s1),
    .scales          (scales)
  );

  // two rows back
  lap5_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_older_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (older_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (older_rdata)
  );

  // one row back
  lap5_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_newer_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (newer_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (newer_rdata)
  );

  // read-modify-write of the stores plus the window; the same column comes
  // back only a full row later, so no forwarding is needed
  lap5_win u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1          (s1),
    .s2_ready    (s2_ready),
    .older_rdata (older_rdata),
    .newer_rdata (newer_rdata),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .older_wdata (older_wdata),
    .newer_wdata (newer_wdata),
    .s3_ready    (s3_ready),
    .s2_valid    (s2_valid),
    .d_row       (d_row),
    .d_col       (d_col),
    .s2_pos      (s2_pos)
  );

  // scaling multiplies, final sum and output register
  lap5_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .scales         (scales),
    .s2_valid       (s2_valid),
    .d_row          (d_row),
    .d_col          (d_col),
    .s2_pos         (s2_pos),
    .s3_ready       (s3_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_laplacian  (out_laplacian),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_last_point (out_last_point)
  );

  // a store entry is never read and written in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("row store read and write hit the same column");

  // every input transfer lands in the first stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted sample missing from first stage");

  // results only for interior points
  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_center_row != '0) && (out_center_col != '0))
    else $error("result produced for a border point");

endmodule

### bench/laplacian_5point_stencil_tb.sv
`timescale 1ns / 1ps
module laplacian_5point_stencil_tb;
  import lap5_pkg::*;

  localparam int TIMEOUT_CYCLES   = 1000000;
  localparam int SETTLE_CYCLES    = 12;   // pipeline is four deep, leave some slack
  localparam int MAX_SHOWN        = 10;
  localparam int RANDOM_ITEMS     = 750;
  localparam int EDGE_ITEMS       = 96;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = '1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 26'd16777216;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  // who idles how often
  typedef enum int {GAPS_SLOW_SINK, GAPS_SLOW_SOURCE, GAPS_NONE} gap_mode_t;

  typedef struct packed {
    logic signed [LAP_W-1:0] laplacian;
    logic [ROW_W-1:0]        center_row;
    logic [COL_W-1:0]        center_col;
    logic                    last_point;
  } stencil_out_t;

  // tracks raster position, line buffers and window, predicts each laplacian
  class stencil_scoreboard;
    int unsigned n_rows;
    int unsigned n_cols;
    logic [SCALE_W-1:0] k_rows;
    logic [SCALE_W-1:0] k_cols;
    logic signed [SAMPLE_W-1:0] line_older [MAX_COLS];
    logic signed [SAMPLE_W-1:0] line_newer [MAX_COLS];
    logic signed [SAMPLE_W-1:0] win [3];
    logic signed [SAMPLE_W-1:0] up_prev;
    logic signed [SAMPLE_W-1:0] here_prev;
    int unsigned row_pos;
    int unsigned col_pos;
    stencil_out_t laplacians_due [$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned frame_ends;

    function new();
      n_rows = MAX_ROWS;
      n_cols = MAX_COLS;
      k_rows = SCALE_RESET;
      k_cols = SCALE_RESET;
      foreach (line_older[i]) line_older[i] = '0;
      foreach (line_newer[i]) line_newer[i] = '0;
      foreach (win[i]) win[i] = '0;
      up_prev = '0;
      here_prev = '0;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
      results_seen = 0;
      frame_ends = 0;
    endfunction

    function int unsigned clamp_extent(logic [EXT_W-1:0] v, int unsigned hi);
      if (v < MIN_EXT) return MIN_EXT;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_ROWS: begin
          n_rows = clamp_extent(data[EXT_W-1:0], MAX_ROWS);
          row_pos = 0;
          col_pos = 0;
        end
        REG_GRID_COLS: begin
          n_cols = clamp_extent(data[EXT_W-1:0], MAX_COLS);
          row_pos = 0;
          col_pos = 0;
        end
        REG_SCALE_ROWS: k_rows = data[SCALE_W-1:0];
        REG_SCALE_COLS: k_cols = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned c;
      int unsigned r;
      logic signed [SAMPLE_W-1:0] up_here;
      logic signed [SAMPLE_W-1:0] above_here;
      longint mid;
      longint d_row;
      longint d_col;
      longint kr;
      longint kc;
      stencil_out_t due;
      c = col_pos;
      r = row_pos;
      up_here = line_older[c];
      above_here = line_newer[c];
      win[0] = win[1];
      win[1] = win[2];
      win[2] = above_here;
      if (r >= 2 && c >= 2) begin
        mid = win[1];
        kr = k_rows;
        kc = k_cols;
        d_row = longint'(up_prev) - 2 * mid + longint'(here_prev);
        d_col = longint'(win[0]) - 2 * mid + longint'(win[2]);
        due.laplacian = kr * d_row + kc * d_col;
        due.center_row = ROW_W'(r - 1);
        due.center_col = COL_W'(c - 1);
        due.last_point = (r + 1 == n_rows) && (c + 1 == n_cols);
        laplacians_due.push_back(due);
      end
      line_older[c] = above_here;
      line_newer[c] = s;
      up_prev = up_here;
      here_prev = s;
      if (c + 1 >= n_cols) begin
        col_pos = 0;
        row_pos = (r + 1 >= n_rows) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0s mismatch: expected %0h, actual %0h", field, want, got);
    endfunction

    function void check_laplacian(logic signed [LAP_W-1:0] lap, logic [ROW_W-1:0] row,
                                  logic [COL_W-1:0] col, logic last);
      stencil_out_t want;
      results_seen++;
      if (last) frame_ends++;
      if (laplacians_due.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("result at row %0d col %0d arrived with nothing expected", row, col);
        return;
      end
      want = laplacians_due.pop_front();
      if (lap !== want.laplacian) report("laplacian", want.laplacian, lap);
      if (row !== want.center_row) report("center_row", want.center_row, row);
      if (col !== want.center_col) report("center_col", want.center_col, col);
      if (last !== want.last_point) report("last_point", want.last_point, last);
    endfunction

    function void flush_leftovers();
      if (laplacians_due.size() != 0) begin
        errors += laplacians_due.size();
        $display("%0d expected results never arrived", laplacians_due.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [LAP_W-1:0] out_laplacian;
  logic [ROW_W-1:0] out_center_row;
  logic [COL_W-1:0] out_center_col;
  logic out_last_point;

  stencil_scoreboard sb;
  gap_mode_t gap_mode = GAPS_SLOW_SINK;
  logic draining = 1'b0;         // forces the sink ready while waiting for idle
  logic long_hold_armed = 1'b0;  // set once by the stimulus, served by the sink
  logic long_hold_done = 1'b0;
  int unsigned long_hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned samples_sent = 0;
  int unsigned cfg_writes = 0;

  laplacian_5point_stencil dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_laplacian   (out_laplacian),
    .out_center_row  (out_center_row),
    .out_center_col  (out_center_col),
    .out_last_point  (out_last_point)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // idle percentages per side
  function automatic int source_gap_pct(gap_mode_t m);
    case (m)
      GAPS_SLOW_SINK:   return 35;
      GAPS_SLOW_SOURCE: return 78;
      default:          return 0;
    endcase
  endfunction

  function automatic int sink_gap_pct(gap_mode_t m);
    case (m)
      GAPS_SLOW_SINK:   return 78;
      GAPS_SLOW_SOURCE: return 35;
      default:          return 0;
    endcase
  endfunction

  // global watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // sink: random stall, one long hold-off while the source keeps offering
  always @(negedge clk) begin
    if (long_hold_armed && !long_hold_done) begin
      long_hold_done <= 1'b1;
      long_hold_left <= LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall <= 1'b1;
    end else if (draining) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < sink_gap_pct(gap_mode));
    end
  end

  // result transfer check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_laplacian(out_laplacian, out_center_row, out_center_col, out_last_point);
  end

  // register write, entered and left at a falling edge
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one sample transfer, with random source gaps ahead of it
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < source_gap_pct(gap_mode)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  // wait for every due result, then let border samples leave the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    draining <= 1'b1;
    while (sb.laplacians_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    draining <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'(int'($urandom_range(511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  // raw extent value: below-minimum, junk above the register, or plain
  function automatic logic [CFG_DATA_W-1:0] pick_extent(int unsigned hi);
    case ($urandom_range(5))
      0: return CFG_DATA_W'($urandom_range(2));
      1: return {13'($urandom), 13'($urandom_range(hi, MIN_EXT))};
      default: return CFG_DATA_W'($urandom_range(hi, MIN_EXT));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return '0;
      1: return SCALE_MAX;
      2: return CFG_DATA_W'($urandom_range(4, 1));
      3: return CFG_DATA_W'(1 << 16);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // 3x3 frame: plus-shaped neighbours around the centre, random corners
  task automatic send_cross(logic signed [SAMPLE_W-1:0] centre,
                            logic signed [SAMPLE_W-1:0] arm);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_sample(centre);
      else if (i % 2 == 1) send_sample(arm);
      else send_sample($urandom);
    end
  endtask

  task automatic random_config();
    if ($urandom_range(3) != 0) begin
      write_cfg(REG_GRID_ROWS, pick_extent(10));
      write_cfg(REG_GRID_COLS, pick_extent(16));
    end
    // scale-only changes keep the frame position
    if ($urandom_range(1) != 0) write_cfg(REG_SCALE_ROWS, pick_scale());
    if ($urandom_range(1) != 0) write_cfg(REG_SCALE_COLS, pick_scale());
  endtask

  initial begin
    int unsigned n_items;
    int unsigned mode_items;
    bit first_phase;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample_value = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: 3x3 frames, extents written below minimum, scales at reset then at maximum
    write_cfg(REG_GRID_ROWS, '0);
    write_cfg(REG_GRID_COLS, CFG_DATA_W'(2));
    send_cross(SAMPLE_MIN, SAMPLE_MAX);   // largest positive laplacian
    send_cross(SAMPLE_MAX, SAMPLE_MIN);   // largest negative laplacian
    settle();
    write_cfg(REG_SCALE_ROWS, SCALE_MAX);
    write_cfg(REG_SCALE_COLS, SCALE_MAX);
    send_cross(SAMPLE_MIN, SAMPLE_MAX);
    settle();

    // widest rows: 8191 clamps to the maximum, start of the first row
    write_cfg(REG_GRID_COLS, {13'($urandom), 13'd8191});
    write_cfg(REG_GRID_ROWS, CFG_DATA_W'(3));
    write_cfg(REG_SCALE_ROWS, pick_scale());
    repeat (EDGE_ITEMS) send_sample(pick_sample());
    settle();

    // tallest grid: 5000 clamps to the maximum, a column of narrow rows
    write_cfg(REG_GRID_ROWS, CFG_DATA_W'(5000));
    write_cfg(REG_GRID_COLS, CFG_DATA_W'(3));
    write_cfg(REG_SCALE_COLS, pick_scale());
    repeat (EDGE_ITEMS) send_sample(pick_sample());
    settle();

    // random phases, one idle pattern per third
    for (int m = 0; m < 3; m++) begin
      gap_mode <= gap_mode_t'(m);
      mode_items = 0;
      first_phase = 1'b1;
      while (mode_items < RANDOM_ITEMS / 3) begin
        settle();
        random_config();
        n_items = $urandom_range(90, 20);
        if (first_phase && gap_mode_t'(m) == GAPS_NONE) begin
          // source streams flat out while the sink holds off
          long_hold_armed <= 1'b1;
          n_items = 200;
        end
        first_phase = 1'b0;
        repeat (n_items) send_sample(pick_sample());
        mode_items += n_items;
      end
    end

    settle();
    sb.flush_leftovers();
    $display("%0d samples transferred, %0d laplacians checked, %0d frame ends",
             samples_sent, sb.results_seen, sb.frame_ends);
    $display("%0d register writes across extent and scale settings, %0d cycles",
             cfg_writes, cycle_count);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
